// File: src/vvr_pkg.sv
// ----------------------------------------------------------------------------
// vvr_pkg: shared types and constants for the vector to vector rotation block
// widths of components, unit vectors and matrix entries, plus stage counts
// ----------------------------------------------------------------------------
package vvr_pkg;

  // field widths
  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int RAND_BITS      = 8;
  localparam int OUT_W          = FRACTION_BITS + 2;

  // unit vectors are q.30
  localparam int UNIT_BITS = 30;
  localparam int U_W       = UNIT_BITS + 2;

  // unitizer input: widest of the perpendicular and the half vector sum
  localparam int P_W   = COMPONENT_BITS + RAND_BITS + 2;
  localparam int S_W   = UNIT_BITS + 3;
  localparam int UIN_W = (P_W > S_W) ? P_W : S_W;

  // unitizer internals
  localparam int NRM_W     = UNIT_BITS + 1;
  localparam int SQ_W      = 2 * NRM_W;
  localparam int N_W       = SQ_W + 2;
  localparam int ROOT_W    = N_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int DIV_STEPS = UNIT_BITS + 1;
  localparam int NUM_W     = NRM_W + UNIT_BITS + 1;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int SH_W      = $clog2(UIN_W + 1);

  // unitizer latency: five front stages, root steps, divider setup,
  // divider steps and the signed output register
  localparam int UNI_LAT = 5 + ROOT_W + 1 + DIV_STEPS + 1;

  // stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((6 * COMPONENT_BITS + 2 * RAND_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((9 * OUT_W + 7) / 8) * 8;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef logic signed [RAND_BITS-1:0]      rnd_t;
  typedef logic signed [UIN_W-1:0]          uin_t;
  typedef logic signed [U_W-1:0]            unit_t;
  typedef logic signed [OUT_W-1:0]          entry_t;

  // per request flags that ride beside the vectors
  typedef struct packed {
    logic ok;
    logic opp;
  } side_t;

endpackage

// File: src/vvr_front.sv
// ----------------------------------------------------------------------------
// vvr_front: input register, cross products and perpendicular candidate
// decides exact opposition and zero inputs, builds the fallback axis
// ----------------------------------------------------------------------------
module vvr_front import vvr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  comp_t a_i [3],
  input  comp_t b_i [3],
  input  rnd_t  ra_i,
  input  rnd_t  rb_i,
  output logic  valid_o,
  output uin_t  a_o [3],
  output uin_t  b_o [3],
  output uin_t  p_o [3],
  output side_t side_o
);

  localparam int CB = COMPONENT_BITS;
  localparam int RP = CB + RAND_BITS;

  comp_t a1_q [3];
  comp_t b1_q [3];
  rnd_t  ra1_q, rb1_q;
  logic  v1_q;

  logic signed [2*CB-1:0] cr_q [6];
  logic signed [RP-1:0]   pr_q [4];
  logic [2:0]             az_q;
  logic                   anz_q, bnz_q, ag_q, v2_q;
  comp_t                  a2_q [3];
  comp_t                  b2_q [3];

  logic [2:0] az_d, bz_d, ag_d;
  logic       par_d;
  uin_t       p_d [3];

  // stage 1: request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a_i;
      b1_q  <= b_i;
      ra1_q <= ra_i;
      rb1_q <= rb_i;
    end
  end

  // zero and sign tests on the raw components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      az_d[i] = (a1_q[i] == '0);
      bz_d[i] = (b1_q[i] == '0);
      ag_d[i] = (a1_q[i][CB-1] && !b1_q[i][CB-1] && !bz_d[i]) ||
                (b1_q[i][CB-1] && !a1_q[i][CB-1] && !az_d[i]);
    end
  end

  // stage 2: cross products and perpendicular products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q[0] <= a1_q[1] * b1_q[2];
      cr_q[1] <= a1_q[2] * b1_q[1];
      cr_q[2] <= a1_q[2] * b1_q[0];
      cr_q[3] <= a1_q[0] * b1_q[2];
      cr_q[4] <= a1_q[0] * b1_q[1];
      cr_q[5] <= a1_q[1] * b1_q[0];
      pr_q[0] <= ra1_q * a1_q[2];
      pr_q[1] <= rb1_q * a1_q[2];
      pr_q[2] <= a1_q[0] * ra1_q;
      pr_q[3] <= a1_q[1] * rb1_q;
      az_q    <= az_d;
      anz_q   <= ~&az_d;
      bnz_q   <= ~&bz_d;
      ag_q    <= |ag_d;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
    end
  end

  // parallel test and axis choice for the opposite case
  always_comb begin
    par_d = (cr_q[0] == cr_q[1]) && (cr_q[2] == cr_q[3]) && (cr_q[4] == cr_q[5]);
    p_d[0] = '0;
    p_d[1] = '0;
    p_d[2] = '0;
    priority if (az_q[0]) begin
      p_d[0] = uin_t'(1);
    end else if (az_q[1]) begin
      p_d[1] = uin_t'(1);
    end else if (az_q[2]) begin
      p_d[2] = uin_t'(1);
    end else begin
      p_d[0] = uin_t'(pr_q[0]);
      p_d[1] = uin_t'(pr_q[1]);
      p_d[2] = -(uin_t'(pr_q[2]) + uin_t'(pr_q[3]));
    end
  end

  // stage 3: flags and vectors toward the unitizers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_o[i] <= uin_t'(a2_q[i]);
        b_o[i] <= uin_t'(b2_q[i]);
        p_o[i] <= p_d[i];
      end
      side_o.ok  <= anz_q && bnz_q;
      side_o.opp <= par_d && ag_q;
    end
  end

endmodule

// File: src/vvr_unitize.sv
// ----------------------------------------------------------------------------
// vvr_unitize: pipelined unit vector in q.30
// normalize, sum of squares, one root digit and one quotient bit per stage
// ----------------------------------------------------------------------------
module vvr_unitize import vvr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  uin_t  vec_i [3],
  output logic  valid_o,
  output logic  nz_o,
  output unit_t unit_o [3]
);

  localparam int MW = UIN_W;

  // stage 1: magnitudes
  logic [MW-1:0] mag_d [3];
  logic [MW-1:0] mag1_q [3];
  logic [2:0]    neg1_q;
  logic [MW-1:0] or1_q;
  logic          v1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][MW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag_d;
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= vec_i[i][MW-1];
      end
      or1_q <= mag_d[0] | mag_d[1] | mag_d[2];
    end
  end

  // stage 2: leading one and shift amount
  logic [SH_W-1:0] pos_d;
  logic [MW-1:0]   mag2_q [3];
  logic [2:0]      neg2_q;
  logic [SH_W-1:0] sh2_q;
  logic            rt2_q, nz2_q, v2_q;

  always_comb begin
    pos_d = '0;
    for (int k = 0; k < MW; k++) begin
      if (or1_q[k]) pos_d = SH_W'(k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      nz2_q  <= (or1_q != '0);
      rt2_q  <= (pos_d > SH_W'(UNIT_BITS));
      sh2_q  <= (pos_d > SH_W'(UNIT_BITS)) ? (pos_d - SH_W'(UNIT_BITS))
                                           : (SH_W'(UNIT_BITS) - pos_d);
    end
  end

  // stage 3: largest magnitude into [2^30, 2^31)
  logic [NRM_W-1:0] nrm3_q [3];
  logic [2:0]       neg3_q;
  logic             nz3_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        nrm3_q[i] <= rt2_q ? NRM_W'(mag2_q[i] >> sh2_q)
                           : (mag2_q[i][NRM_W-1:0] << sh2_q);
      end
      neg3_q <= neg2_q;
      nz3_q  <= nz2_q;
    end
  end

  // stage 4: squares
  logic [SQ_W-1:0]  sq4_q [3];
  logic [NRM_W-1:0] nrm4_q [3];
  logic [2:0]       neg4_q;
  logic             nz4_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= nrm3_q[i] * nrm3_q[i];
      end
      nrm4_q <= nrm3_q;
      neg4_q <= neg3_q;
      nz4_q  <= nz3_q;
    end
  end

  // square root chain, entry 0 holds the sum of squares
  logic [REM_W-1:0]  sr_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root_q [ROOT_W+1];
  logic [N_W-1:0]    sr_n_q    [ROOT_W+1];
  logic [NRM_W-1:0]  sr_mag_q  [ROOT_W+1][3];
  logic [2:0]        sr_neg_q  [ROOT_W+1];
  logic              sr_nz_q   [ROOT_W+1];
  logic              sr_v_q    [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v_q[0] <= 1'b0;
    end else if (en_i) begin
      sr_v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
      sr_n_q[0]    <= N_W'(sq4_q[0]) + N_W'(sq4_q[1]) + N_W'(sq4_q[2]);
      sr_mag_q[0]  <= nrm4_q;
      sr_neg_q[0]  <= neg4_q;
      sr_nz_q[0]   <= nz4_q;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W-1:0]  t_rem, trial, rem_nx;
    logic [ROOT_W-1:0] root_nx;

    // one root digit: bring in two bits, try subtracting 4r+1
    always_comb begin
      t_rem = {sr_rem_q[k][REM_W-3:0], sr_n_q[k][N_W-1 -: 2]};
      trial = REM_W'({sr_root_q[k], 2'b01});
      if (t_rem >= trial) begin
        rem_nx  = t_rem - trial;
        root_nx = {sr_root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nx  = t_rem;
        root_nx = {sr_root_q[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sr_v_q[k+1] <= sr_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_rem_q[k+1]  <= rem_nx;
        sr_root_q[k+1] <= root_nx;
        sr_n_q[k+1]    <= sr_n_q[k] << 2;
        sr_mag_q[k+1]  <= sr_mag_q[k];
        sr_neg_q[k+1]  <= sr_neg_q[k];
        sr_nz_q[k+1]   <= sr_nz_q[k];
      end
    end
  end

  // divider chain, entry 0 holds the rounded numerators
  logic [DREM_W-1:0]    dv_rem_q [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_low_q [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_quo_q [DIV_STEPS+1][3];
  logic [ROOT_W-1:0]    dv_r_q   [DIV_STEPS+1];
  logic [2:0]           dv_neg_q [DIV_STEPS+1];
  logic                 dv_nz_q  [DIV_STEPS+1];
  logic                 dv_v_q   [DIV_STEPS+1];
  logic [NUM_W-1:0]     num_d    [3];

  // numerator mag * 2^30 + r/2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NUM_W'(sr_mag_q[ROOT_W][i]) << UNIT_BITS) +
                 NUM_W'(sr_root_q[ROOT_W] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= sr_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= DREM_W'(num_d[i] >> DIV_STEPS);
        dv_low_q[0][i] <= num_d[i][DIV_STEPS-1:0];
        dv_quo_q[0][i] <= '0;
      end
      dv_r_q[0]   <= sr_root_q[ROOT_W];
      dv_neg_q[0] <= sr_neg_q[ROOT_W];
      dv_nz_q[0]  <= sr_nz_q[ROOT_W];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DREM_W-1:0]    t_rem [3];
    logic [DREM_W-1:0]    rem_nx [3];
    logic [DIV_STEPS-1:0] quo_nx [3];

    // one quotient bit per lane
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t_rem[i] = {dv_rem_q[k][i][DREM_W-2:0], dv_low_q[k][i][DIV_STEPS-1]};
        if (t_rem[i] >= DREM_W'(dv_r_q[k])) begin
          rem_nx[i] = t_rem[i] - DREM_W'(dv_r_q[k]);
          quo_nx[i] = {dv_quo_q[k][i][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_nx[i] = t_rem[i];
          quo_nx[i] = {dv_quo_q[k][i][DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k+1][i] <= rem_nx[i];
          dv_low_q[k+1][i] <= dv_low_q[k][i] << 1;
          dv_quo_q[k+1][i] <= quo_nx[i];
        end
        dv_r_q[k+1]   <= dv_r_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_nz_q[k+1]  <= dv_nz_q[k];
      end
    end
  end

  // output: sign back on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        unit_o[i] <= dv_neg_q[DIV_STEPS][i] ? -unit_t'({1'b0, dv_quo_q[DIV_STEPS][i]})
                                            : unit_t'({1'b0, dv_quo_q[DIV_STEPS][i]});
      end
      nz_o <= dv_nz_q[DIV_STEPS];
    end
  end

endmodule

// File: src/vvr_matrix.sv
// ----------------------------------------------------------------------------
// vvr_matrix: r = 2*m*m^t - i from the q.30 half vector
// products, rounding to q1.14, diagonal offset and saturation
// ----------------------------------------------------------------------------
module vvr_matrix import vvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  logic   ok_i,
  input  unit_t  m_i [3],
  output logic   valid_o,
  output logic   zero_o,
  output entry_t ent_o [9]
);

  localparam int PR_W   = 2 * U_W;
  localparam int RND_SH = 2 * UNIT_BITS - FRACTION_BITS;
  localparam int MG_W   = OUT_W + 1;
  localparam int E_W    = OUT_W + 2;
  localparam logic [PR_W:0]         RND = (PR_W + 1)'(1) << (RND_SH - 1);
  localparam logic signed [E_W-1:0] ONE = E_W'(1) << FRACTION_BITS;

  // product slot for each entry, row major
  function automatic int slot(input int e);
    int r, c, lo, hi;
    r  = e / 3;
    c  = e % 3;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    return (lo == 0) ? hi : ((lo == 1) ? hi + 2 : 5);
  endfunction

  // stage 1: the six distinct products
  logic signed [PR_W-1:0] pr1_q [6];
  logic                   ok1_q, v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr1_q[0] <= m_i[0] * m_i[0];
      pr1_q[1] <= m_i[0] * m_i[1];
      pr1_q[2] <= m_i[0] * m_i[2];
      pr1_q[3] <= m_i[1] * m_i[1];
      pr1_q[4] <= m_i[1] * m_i[2];
      pr1_q[5] <= m_i[2] * m_i[2];
      ok1_q    <= ok_i;
    end
  end

  // stage 2: doubled magnitude rounded half away from zero
  logic [PR_W-1:0] ab_d [6];
  logic [PR_W:0]   rs_d [6];
  logic [MG_W-1:0] mg2_q [6];
  logic [5:0]      neg2_q;
  logic            ok2_q, v2_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ab_d[i] = pr1_q[i][PR_W-1] ? (~pr1_q[i] + 1'b1) : pr1_q[i];
      rs_d[i] = ({ab_d[i], 1'b0} + RND) >> RND_SH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        mg2_q[i]  <= rs_d[i][MG_W-1:0];
        neg2_q[i] <= pr1_q[i][PR_W-1];
      end
      ok2_q <= ok1_q;
    end
  end

  // stage 3: sign, diagonal, saturation, all zero when not ok
  logic signed [E_W-1:0] ev_d [9];

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      ev_d[e] = E_W'(mg2_q[slot(e)]);
      if (neg2_q[slot(e)]) ev_d[e] = -ev_d[e];
      if (e % 4 == 0) ev_d[e] = ev_d[e] - ONE;
      if (ev_d[e] > ONE) ev_d[e] = ONE;
      if (ev_d[e] < -ONE) ev_d[e] = -ONE;
      if (!ok2_q) ev_d[e] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int e = 0; e < 9; e++) begin
        ent_o[e] <= ev_d[e][OUT_W-1:0];
      end
      zero_o <= !ok2_q;
    end
  end

endmodule

// File: src/vector_to_vector_rotation.sv
// ----------------------------------------------------------------------------
// vector_to_vector_rotation: rotation matrix carrying one vector onto another
// half vector form, r = 2*m*m^t - i, entries in q1.14
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream carries a source vector, a target
// vector and two random hundredths for the opposite case. The master stream
// returns one 3x3 matrix per request, row major, with a zero-length flag on
// tuser; when that flag is set all entries read zero.
// Throughput is one request per cycle while the receiver keeps up. The pipeline
// runs through three front stages, two unitizers in sequence of UNI_LAT stages
// each (one root digit and one quotient bit per stage), the half vector sum and
// three matrix stages.
// Reset clears every valid bit, so the pipeline comes up empty.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver stalls with a result waiting, every stage holds and
// s_axis_tready_o drops until the result is taken, so nothing is lost.
// ----------------------------------------------------------------------------
module vector_to_vector_rotation import vvr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z, random_a, random_b
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // zero_vector
  output logic                  m_axis_tuser_o
);

  localparam int CB = COMPONENT_BITS;

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // unpack the request
  comp_t in_a [3];
  comp_t in_b [3];
  rnd_t  in_ra, in_rb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata_i[i*CB +: CB];
      in_b[i] = s_axis_tdata_i[(i+3)*CB +: CB];
    end
    in_ra = s_axis_tdata_i[6*CB +: RAND_BITS];
    in_rb = s_axis_tdata_i[6*CB+RAND_BITS +: RAND_BITS];
  end

  // front: opposition test and perpendicular candidate
  logic  fr_v;
  uin_t  fr_a [3];
  uin_t  fr_b [3];
  uin_t  fr_p [3];
  side_t fr_side;

  vvr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .a_i     (in_a),
    .b_i     (in_b),
    .ra_i    (in_ra),
    .rb_i    (in_rb),
    .valid_o (fr_v),
    .a_o     (fr_a),
    .b_o     (fr_b),
    .p_o     (fr_p),
    .side_o  (fr_side)
  );

  // first level: unit source and target
  logic  u1_v, u1_nz, u2_v, u2_nz;
  unit_t u1 [3];
  unit_t u2 [3];

  vvr_unitize u_unit_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .vec_i   (fr_a),
    .valid_o (u1_v),
    .nz_o    (u1_nz),
    .unit_o  (u1)
  );

  vvr_unitize u_unit_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .vec_i   (fr_b),
    .valid_o (u2_v),
    .nz_o    (u2_nz),
    .unit_o  (u2)
  );

  // side data delayed alongside the first level
  side_t d1_side_q [UNI_LAT];
  uin_t  d1_p_q    [UNI_LAT][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_side_q[0] <= fr_side;
      d1_p_q[0]    <= fr_p;
      for (int k = 1; k < UNI_LAT; k++) begin
        d1_side_q[k] <= d1_side_q[k-1];
        d1_p_q[k]    <= d1_p_q[k-1];
      end
    end
  end

  // half vector sum
  uin_t  g_s_q [3];
  uin_t  g_p_q [3];
  side_t g_side_q;
  logic  g_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= u1_v && u2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g_s_q[i] <= uin_t'(u1[i]) + uin_t'(u2[i]);
      end
      g_p_q        <= d1_p_q[UNI_LAT-1];
      g_side_q.opp <= d1_side_q[UNI_LAT-1].opp;
      g_side_q.ok  <= d1_side_q[UNI_LAT-1].ok && u1_nz && u2_nz;
    end
  end

  // opposite or cancelled sum falls back to the perpendicular
  logic use_p;
  uin_t h_vec [3];

  always_comb begin
    use_p = g_side_q.opp ||
            (g_s_q[0] == '0 && g_s_q[1] == '0 && g_s_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      h_vec[i] = use_p ? g_p_q[i] : g_s_q[i];
    end
  end

  // second level: unit half vector
  logic  m_v, m_nz;
  unit_t m_vec [3];

  vvr_unitize u_unit_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .vec_i   (h_vec),
    .valid_o (m_v),
    .nz_o    (m_nz),
    .unit_o  (m_vec)
  );

  logic d2_ok_q [UNI_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_ok_q[0] <= g_side_q.ok;
      for (int k = 1; k < UNI_LAT; k++) begin
        d2_ok_q[k] <= d2_ok_q[k-1];
      end
    end
  end

  // matrix and output register
  entry_t ent [9];

  vvr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_v),
    .ok_i    (d2_ok_q[UNI_LAT-1] && m_nz),
    .m_i     (m_vec),
    .valid_o (m_axis_tvalid_o),
    .zero_o  (m_axis_tuser_o),
    .ent_o   (ent)
  );

  // pack the result
  always_comb begin
    m_axis_tdata_o = '0;
    for (int e = 0; e < 9; e++) begin
      m_axis_tdata_o[e*OUT_W +: OUT_W] = ent[e];
    end
  end

endmodule

// File: tb/vvr_checker.sv
// ----------------------------------------------------------------------------
// vvr_checker: watches both streams of the rotation block and checks results
// each accepted request is turned into an expected matrix by a local model;
// each accepted result is compared entry by entry with the oldest expectation
// ----------------------------------------------------------------------------
module vvr_checker import vvr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tuser_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    matrix_count_o
);

  typedef struct packed {
    logic                  zero_vec;
    logic [9*OUT_W-1:0]    entries;
  } matrix_t;

  matrix_t expected_matrices[$];

  // floor square root of a 64 bit value
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // scale a vector to unit length in q.30; returns 0 for the zero vector
  function automatic bit to_unit(input longint c[3], output longint u[3]);
    logic [63:0] mag[3];
    logic [63:0] mx;
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] q;
    bit          neg[3];
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
      u[i] = 0;
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    root = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << UNIT_BITS) + (root >> 1)) / root;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  // rotation matrix for one request
  function automatic matrix_t rotation_of(input logic [IN_DATA_W-1:0] d);
    longint  a[3], b[3], u1[3], u2[3], s[3], m[3], p[3];
    longint  ra, rb, e, prod, mg;
    longint  one;
    bit      ok, opposite, parallel, against;
    matrix_t res;
    one = longint'(1) << FRACTION_BITS;
    for (int i = 0; i < 3; i++) begin
      a[i] = comp_t'(d[i*COMPONENT_BITS +: COMPONENT_BITS]);
      b[i] = comp_t'(d[(i+3)*COMPONENT_BITS +: COMPONENT_BITS]);
    end
    ra = rnd_t'(d[6*COMPONENT_BITS +: RAND_BITS]);
    rb = rnd_t'(d[6*COMPONENT_BITS+RAND_BITS +: RAND_BITS]);
    ok = !(a[0] == 0 && a[1] == 0 && a[2] == 0) && !(b[0] == 0 && b[1] == 0 && b[2] == 0);
    opposite = 0;
    if (ok) begin
      parallel = a[1]*b[2] == a[2]*b[1] && a[2]*b[0] == a[0]*b[2] &&
                 a[0]*b[1] == a[1]*b[0];
      against = 0;
      for (int i = 0; i < 3; i++)
        if ((a[i] < 0 && b[i] > 0) || (a[i] > 0 && b[i] < 0)) against = 1;
      opposite = parallel && against;
      if (!opposite) begin
        void'(to_unit(a, u1));
        void'(to_unit(b, u2));
        for (int i = 0; i < 3; i++) s[i] = u1[i] + u2[i];
        if (!to_unit(s, m)) opposite = 1;
      end
      // perpendicular of the source: first zero axis, else from random values
      if (opposite) begin
        p = '{0, 0, 0};
        if (a[0] == 0) p[0] = 1;
        else if (a[1] == 0) p[1] = 1;
        else if (a[2] == 0) p[2] = 1;
        else begin
          p[0] = ra * a[2];
          p[1] = rb * a[2];
          p[2] = -(a[0]*ra + a[1]*rb);
        end
        ok = to_unit(p, m);
      end
    end
    res.zero_vec = !ok;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e = 0;
        if (ok) begin
          prod = 2 * m[i] * m[j];
          mg = prod < 0 ? -prod : prod;
          mg = (mg + (longint'(1) << (2*UNIT_BITS - FRACTION_BITS - 1)))
               >> (2*UNIT_BITS - FRACTION_BITS);
          e = prod < 0 ? -mg : mg;
          if (i == j) e = e - one;
          if (e > one) e = one;
          if (e < -one) e = -one;
        end
        res.entries[(i*3+j)*OUT_W +: OUT_W] = e[OUT_W-1:0];
      end
    end
    return res;
  endfunction

  assign pending_o = expected_matrices.size();

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    matrix_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      matrix_count_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) expected_matrices.push_back(rotation_of(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        matrix_count_o <= matrix_count_o + 1;
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected result %h flag %b", $time, m_tdata_i, m_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_matrices.pop_front();
          if (want.entries != m_tdata_i[9*OUT_W-1:0] || want.zero_vec != m_tuser_i) begin
            $display("%0t: mismatch expected %h flag %b actual %h flag %b", $time,
                     want.entries, want.zero_vec, m_tdata_i[9*OUT_W-1:0], m_tuser_i);
            for (int k = 0; k < 9; k++)
              if (want.entries[k*OUT_W +: OUT_W] != m_tdata_i[k*OUT_W +: OUT_W])
                $display("%0t:   m%0d%0d expected %0d actual %0d", $time, k/3, k%3,
                         entry_t'(want.entries[k*OUT_W +: OUT_W]),
                         entry_t'(m_tdata_i[k*OUT_W +: OUT_W]));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the vector to vector rotation block
// directed corner vectors then random pairs, weighted toward parallel and
// opposite pairs, under phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
module tb_top import vvr_pkg::*;;

  localparam int LATENCY    = 2 * UNI_LAT + 7;
  localparam int WATCHDOG   = 20 * LATENCY + 2000;
  localparam int RAND_COUNT = 950;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  int                    fail_count;
  int                    pending;
  int                    matrix_count;
  int                    idle_pct;
  int                    stall_pct;
  int                    quiet_cycles;
  int                    request_count;

  vector_to_vector_rotation u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  vvr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .m_tuser_i      (m_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .matrix_count_o (matrix_count)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(input comp_t f[3], input comp_t g[3],
                                                        input rnd_t ra, input rnd_t rb);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[i*COMPONENT_BITS +: COMPONENT_BITS]     = f[i];
      d[(i+3)*COMPONENT_BITS +: COMPONENT_BITS] = g[i];
    end
    d[6*COMPONENT_BITS +: RAND_BITS]           = ra;
    d[6*COMPONENT_BITS+RAND_BITS +: RAND_BITS] = rb;
    return d;
  endfunction

  // one request: optional idle gap, then hold until accepted
  task automatic send_request(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    request_count++;
  endtask

  task automatic send_vectors(input int fx, input int fy, input int fz, input int gx,
                              input int gy, input int gz, input int ra, input int rb);
    comp_t f[3];
    comp_t g[3];
    f = '{comp_t'(fx), comp_t'(fy), comp_t'(fz)};
    g = '{comp_t'(gx), comp_t'(gy), comp_t'(gz)};
    send_request(pack_request(f, g, rnd_t'(ra), rnd_t'(rb)));
  endtask

  function automatic int rand_comp(input int spread);
    int v;
    case (spread)
      0: v = int'($urandom_range(65535)) - 32768;
      1: v = int'($urandom_range(40)) - 20;
      default: v = int'($urandom_range(1)) ? 32767 : -32768;
    endcase
    return v;
  endfunction

  // random pair: general, parallel, opposite, or with a zero vector
  task automatic send_random_pair();
    int f[3];
    int g[3];
    int kind;
    int k;
    int ra;
    int rb;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      f[i] = ($urandom_range(3) == 0) ? 0 : rand_comp($urandom_range(9) < 6 ? 0 :
                                                      ($urandom_range(3) == 0 ? 2 : 1));
      g[i] = rand_comp($urandom_range(9) < 7 ? 0 : 1);
    end
    if (kind < 30) begin
      // scaled copy of the source, either sign
      k = int'($urandom_range(3)) + 1;
      if ($urandom_range(1)) k = -k;
      for (int i = 0; i < 3; i++) begin
        f[i] = f[i] / 4;
        g[i] = f[i] * k;
      end
    end else if (kind < 38) begin
      for (int i = 0; i < 3; i++) g[i] = (kind < 34) ? 0 : g[i];
      if (kind >= 34) f = '{0, 0, 0};
    end
    ra = ($urandom_range(9) == 0) ? int'($urandom_range(255)) - 128
                                  : int'($urandom_range(199)) - 100;
    rb = ($urandom_range(9) == 0) ? int'($urandom_range(255)) - 128
                                  : int'($urandom_range(199)) - 100;
    if ($urandom_range(30) == 0) begin
      ra = 0;
      rb = 0;
    end
    send_vectors(f[0], f[1], f[2], g[0], g[1], g[2], ra, rb);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    request_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_vectors(32767, 0, 0, 0, 32767, 0, 0, 0);
    send_vectors(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0);
    send_vectors(1, 2, 3, 1, 2, 3, 0, 0);
    send_vectors(0, 0, 0, 5, 6, 7, 10, 20);
    send_vectors(5, 6, 7, 0, 0, 0, 10, 20);
    send_vectors(0, 0, 0, 0, 0, 0, 0, 0);
    send_vectors(0, 3, 4, 0, -6, -8, 50, 50);
    send_vectors(3, 0, 4, -3, 0, -4, 50, 50);
    send_vectors(3, 4, 0, -3, -4, 0, 50, 50);
    send_vectors(3, 4, 5, -6, -8, -10, 99, -100);
    send_vectors(3, 4, 5, -3, -4, -5, 0, 0);
    send_vectors(3, 4, 5, -3, -4, -5, 127, -128);
    send_vectors(-32768, 32767, -1, 32767, -32768, 1, -100, 99);
    send_vectors(32767, 32767, 32767, -32767, -32767, -32767, -1, 1);
    send_vectors(32767, 1, 0, -32767, -1, 1, 33, 44);
    send_vectors(-1, -1, -1, -1, -1, -1, 0, 0);
    send_vectors(1, 0, 0, -1, 0, 0, 0, 0);
    send_vectors(-21846, 21845, 1, 21845, -21846, -1, -85, 42);

    // random phases: none, sender idle, receiver stall, both, none
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin idle_pct = 52; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 52; end
        3: begin idle_pct = 27; stall_pct = 27; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < RAND_COUNT / 5; n++) send_random_pair();
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d vector pairs (corners, parallel, opposite, zero length)", request_count);
    $display("checked %0d matrices across idle and stall phases", matrix_count);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
src/vvr_pkg.sv
src/vvr_front.sv
src/vvr_unitize.sv
src/vvr_matrix.sv
src/vector_to_vector_rotation.sv
tb/vvr_checker.sv
tb/tb_top.sv
